### rtl/spt_pkg.sv
// Shared types and constants of the script push-data tokenizer.
package spt_pkg;

  // Push opcodes with an explicit little-endian length field, and the zero opcode.
  localparam logic [7:0] OpPush1 = 8'h4C;
  localparam logic [7:0] OpPush2 = 8'h4D;
  localparam logic [7:0] OpPush4 = 8'h4E;
  localparam logic [7:0] OpZero  = 8'h00;

  // Where the parser stands within the current token.
  typedef enum logic [1:0] {
    PhaseOpcode  = 2'd0,
    PhaseLength  = 2'd1,
    PhasePayload = 2'd2
  } phase_e;

  // Role of a byte within its token.
  typedef enum logic [1:0] {
    RoleOpcode  = 2'd0,
    RoleLength  = 2'd1,
    RolePayload = 2'd2
  } role_e;

  // Truncation error codes.
  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrLength  = 2'd1,
    ErrPayload = 2'd2
  } err_e;

  // One script byte as taken from the input stream.
  typedef struct packed {
    logic [7:0] script_byte;
    logic       end_of_script;
  } in_item_t;

  // One result request.
  typedef struct packed {
    role_e       byte_role;
    logic [7:0]  byte_value;
    logic [7:0]  current_opcode;
    logic [31:0] push_length;
    logic        is_push;
    logic        token_end;
    err_e        error_code;
  } result_t;

endpackage

### rtl/spt_in_reg.sv
// Input register: holds one accepted byte until the parser consumes it.
module spt_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  spt_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              take_i,
  output spt_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  spt_pkg::in_item_t item_q;

  // A new byte may enter when the register is empty or is being consumed.
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/spt_parse.sv
// Token parser: holds the parse state and classifies one byte per cycle while step_i is high.
module spt_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  spt_pkg::in_item_t item_i,
  output spt_pkg::result_t  result_o
);

  spt_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_opcode_q, held_opcode_d;
  logic [2:0]      len_left_q, len_left_d;
  logic [1:0]      len_idx_q, len_idx_d;
  logic [31:0]     len_acc_q, len_acc_d;
  logic [31:0]     pay_left_q, pay_left_d;

  logic [7:0]      b;
  logic            last;
  logic [31:0]     acc_new;
  logic [2:0]      len_left_new;
  logic [31:0]     pay_left_new;

  assign b    = item_i.script_byte;
  assign last = item_i.end_of_script;

  // Length byte merged into the accumulator at its little-endian place.
  assign acc_new      = len_acc_q | ({24'd0, b} << {len_idx_q, 3'b000});
  assign len_left_new = len_left_q - 3'd1;
  assign pay_left_new = pay_left_q - 32'd1;

  // Classification of the byte into the result request.
  always_comb begin
    result_o.byte_role      = spt_pkg::RoleOpcode;
    result_o.byte_value     = b;
    result_o.current_opcode = b;
    result_o.push_length    = 32'd0;
    result_o.is_push        = 1'b0;
    result_o.token_end      = 1'b0;
    result_o.error_code     = spt_pkg::ErrNone;

    unique case (phase_q)
      spt_pkg::PhaseLength: begin
        result_o.byte_role      = spt_pkg::RoleLength;
        result_o.current_opcode = held_opcode_q;
        result_o.is_push        = 1'b1;
        result_o.push_length    = acc_new;
        if (len_left_new == 3'd0) begin
          if (acc_new == 32'd0) begin
            // A zero-length push ends on its last length byte.
            result_o.token_end = 1'b1;
          end else if (last) begin
            result_o.error_code = spt_pkg::ErrPayload;
          end
        end else if (last) begin
          result_o.error_code = spt_pkg::ErrLength;
        end
      end
      spt_pkg::PhasePayload: begin
        result_o.byte_role      = spt_pkg::RolePayload;
        result_o.current_opcode = held_opcode_q;
        result_o.is_push        = 1'b1;
        result_o.push_length    = len_acc_q;
        if (pay_left_new == 32'd0) begin
          result_o.token_end = 1'b1;
        end else if (last) begin
          result_o.error_code = spt_pkg::ErrPayload;
        end
      end
      default: begin
        // Opcode byte; the unused phase code is read the same way.
        if (b == spt_pkg::OpZero || b > spt_pkg::OpPush4) begin
          result_o.token_end = 1'b1;
        end else if (b < spt_pkg::OpPush1) begin
          result_o.is_push     = 1'b1;
          result_o.push_length = {24'd0, b};
          if (last) begin
            result_o.error_code = spt_pkg::ErrPayload;
          end
        end else begin
          result_o.is_push = 1'b1;
          if (last) begin
            result_o.error_code = spt_pkg::ErrLength;
          end
        end
      end
    endcase
  end

  // Next parse state after the byte.
  always_comb begin
    phase_d       = phase_q;
    held_opcode_d = held_opcode_q;
    len_left_d    = len_left_q;
    len_idx_d     = len_idx_q;
    len_acc_d     = len_acc_q;
    pay_left_d    = pay_left_q;

    unique case (phase_q)
      spt_pkg::PhaseLength: begin
        len_acc_d  = acc_new;
        len_idx_d  = len_idx_q + 2'd1;
        len_left_d = len_left_new;
        if (len_left_new == 3'd0) begin
          if (acc_new == 32'd0) begin
            phase_d = spt_pkg::PhaseOpcode;
          end else begin
            pay_left_d = acc_new;
            phase_d    = spt_pkg::PhasePayload;
          end
        end
      end
      spt_pkg::PhasePayload: begin
        pay_left_d = pay_left_new;
        if (pay_left_new == 32'd0) begin
          phase_d = spt_pkg::PhaseOpcode;
        end
      end
      default: begin
        held_opcode_d = b;
        len_idx_d     = 2'd0;
        len_acc_d     = 32'd0;
        pay_left_d    = 32'd0;
        len_left_d    = 3'd0;
        if (b == spt_pkg::OpZero || b > spt_pkg::OpPush4) begin
          phase_d = spt_pkg::PhaseOpcode;
        end else if (b < spt_pkg::OpPush1) begin
          len_acc_d  = {24'd0, b};
          pay_left_d = {24'd0, b};
          phase_d    = spt_pkg::PhasePayload;
        end else begin
          if (b == spt_pkg::OpPush1) begin
            len_left_d = 3'd1;
          end else if (b == spt_pkg::OpPush2) begin
            len_left_d = 3'd2;
          end else begin
            len_left_d = 3'd4;
          end
          phase_d = spt_pkg::PhaseLength;
        end
      end
    endcase

    // The end of a script returns all state to its reset values.
    if (last) begin
      phase_d       = spt_pkg::PhaseOpcode;
      held_opcode_d = 8'd0;
      len_left_d    = 3'd0;
      len_idx_d     = 2'd0;
      len_acc_d     = 32'd0;
      pay_left_d    = 32'd0;
    end
  end

  // Parse state advances once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= spt_pkg::PhaseOpcode;
      held_opcode_q <= 8'd0;
      len_left_q    <= 3'd0;
      len_idx_q     <= 2'd0;
      len_acc_q     <= 32'd0;
      pay_left_q    <= 32'd0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      held_opcode_q <= held_opcode_d;
      len_left_q    <= len_left_d;
      len_idx_q     <= len_idx_d;
      len_acc_q     <= len_acc_d;
      pay_left_q    <= pay_left_d;
    end
  end

endmodule

### rtl/spt_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module spt_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  spt_pkg::result_t result_i,
  output logic             valid_o,
  input  logic             ready_i,
  output spt_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  spt_pkg::result_t result_q;

  // Room for a new result when empty or when the held one leaves now.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### rtl/script_push_data_tokenizer.sv
// Script push-data tokenizer: one result per script byte.
// Path: a byte waits in the input register, is parsed combinationally, and its result is
// registered in the result register, from which it is offered on the master side.
// Throughput: one byte per cycle while the master side takes results; back-pressure stalls the parse step.
// Reset: asynchronous, active low; clears both valid flags and the parse state.
module script_push_data_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] script_byte
  input  logic        s_axis_tlast_i,   // end_of_script
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] byte_value, [15:8] current_opcode,
                                        // [47:16] push_length
  output logic [4:0]  m_axis_tuser_o,   // [1:0] byte_role, [2] is_push, [4:3] error_code
  output logic        m_axis_tlast_o    // token_end
);

  spt_pkg::in_item_t in_item, held_item;
  spt_pkg::result_t  parse_res, out_res;
  logic              held_valid;
  logic              out_ready;
  logic              step;

  assign in_item.script_byte   = s_axis_tdata_i;
  assign in_item.end_of_script = s_axis_tlast_i;

  // The parser consumes the held byte whenever the result register has room.
  assign step = held_valid && out_ready;

  spt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (step),
    .item_o  (held_item)
  );

  spt_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (held_item),
    .result_o (parse_res)
  );

  spt_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (held_valid),
    .ready_o  (out_ready),
    .result_i (parse_res),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  // Pack the result onto the master side.
  assign m_axis_tdata_o = {out_res.push_length, out_res.current_opcode, out_res.byte_value};
  assign m_axis_tuser_o = {out_res.error_code, out_res.is_push, out_res.byte_role};
  assign m_axis_tlast_o = out_res.token_end;

endmodule
